// File: hdl/fbba_pkg.sv
// ----------------------------------------------------------------------------
// Free-block bitmap allocator: shared package
// Word geometry, request and status codes, and the bit unit's interface types.
// ----------------------------------------------------------------------------
package fbba_pkg;

  // Map word geometry
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;
  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  // Field widths
  localparam int unsigned BLK_W = 10;
  localparam int unsigned CFG_W = 11;

  // Configuration register indexes
  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  // Request codes
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FORMAT  = 2'd2,
    OP_UNDEF   = 2'd3
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FREEREL = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  // Bit unit operations
  typedef enum logic [1:0] {
    BU_SET_LOW = 2'd0,
    BU_CLEAR   = 2'd1,
    BU_FILL    = 2'd2
  } bu_op_e;

  // Bit unit results
  typedef struct packed {
    logic                 all_ones;
    logic                 hit;
    logic [BIT_W-1:0]     low_idx;
    logic [WORD_BITS-1:0] word;
  } bu_res_t;

endpackage

// File: hdl/fbba_map.sv
// ----------------------------------------------------------------------------
// Free-block bitmap allocator: usage map memory
// One write port and one read port with registered read data; no reset.
// ----------------------------------------------------------------------------
module fbba_map #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [fbba_pkg::WORD_BITS-1:0] wdata_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [fbba_pkg::WORD_BITS-1:0] rdata_o
);
  import fbba_pkg::*;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/fbba_bitunit.sv
// ----------------------------------------------------------------------------
// Free-block bitmap allocator: shared bit unit
// Finds the lowest clear bit of a map word and builds the updated word for
// allocate, release and format.
// ----------------------------------------------------------------------------
module fbba_bitunit (
  input  fbba_pkg::bu_op_e                op_i,
  input  logic [fbba_pkg::WORD_BITS-1:0]  word_i,
  input  logic [fbba_pkg::BIT_W-1:0]      idx_i,
  input  logic                            fill_lt_i,
  input  logic                            fill_eq_i,
  output fbba_pkg::bu_res_t               res_o
);
  import fbba_pkg::*;

  logic [WORD_BITS-1:0] inv;
  logic [WORD_BITS-1:0] low_oh;
  logic [WORD_BITS-1:0] idx_oh;
  logic [WORD_BITS-1:0] rem_mask;
  logic [BIT_W-1:0]     low_idx;

  // Isolate the lowest clear bit as a one-hot mask
  assign inv      = ~word_i;
  assign low_oh   = inv & (~inv + 32'd1);
  assign idx_oh   = 32'd1 << idx_i;
  assign rem_mask = idx_oh - 32'd1;

  // Encode the one-hot mask
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < int'(WORD_BITS); i++) begin
      if (low_oh[i]) begin
        low_idx = low_idx | BIT_W'(i);
      end
    end
  end

  // Word update
  always_comb begin
    res_o.all_ones = &word_i;
    res_o.hit      = |(word_i & idx_oh);
    res_o.low_idx  = low_idx;
    case (op_i)
      BU_SET_LOW: res_o.word = word_i | low_oh;
      BU_CLEAR:   res_o.word = word_i & ~idx_oh;
      BU_FILL:    res_o.word = fill_lt_i ? FULL_WORD : (fill_eq_i ? rem_mask : '0);
      default:    res_o.word = word_i;
    endcase
  end

endmodule

// File: hdl/free_block_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// Free-block bitmap allocator core
// First-fit block allocator over a bitmap of 32-bit words, with release and
// format requests, run by a small sequencer around one bit unit.
// ----------------------------------------------------------------------------
// Usage:
//   A request (opcode_i, block_number_i) is taken at a clock edge where start_i
//   is high and busy_o is low. Its single result appears on allocated_block_o
//   and status_o for exactly one cycle, marked by done_o; the receiver must
//   capture it then, there is no back-pressure.
//   Steps of each request, from the accepting edge to the done_o strobe:
//     allocate: scan the map words from word 0 and set the lowest clear bit of
//               the first word that has one (one map word is read and checked per cycle).
//     release:  map read, check, write back if the block was in use.
//     format:   one map word written per cycle.
//     out-of-range release or undefined opcode: answered from idle, map untouched.
//   One request at a time is handled over the single map memory port pair.
//   After reset the map is zeroed by a sweep with busy_o high; configuration
//   writes are taken at any time through cfg_we_i.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator_core #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [fbba_pkg::CFG_W-1:0]  cfg_data_i,
  // Request channel
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  opcode_i,
  input  logic [fbba_pkg::BLK_W-1:0]  block_number_i,
  // Result channel
  output logic                        done_o,
  output logic [fbba_pkg::BLK_W-1:0]  allocated_block_o,
  output logic [1:0]                  status_o
);
  import fbba_pkg::*;

  localparam int unsigned MAP_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = (PW > 6) ? PW : 6;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RRD  = 3'd2;
  localparam logic [2:0] S_RCHK = 3'd3;
  localparam logic [2:0] S_FMT  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [PW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    chk_q, chk_d;
  logic             pend_q, pend_d;
  logic             clr_q, clr_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [PW-1:0]    full_q, full_d;
  logic [BIT_W-1:0] rem_q, rem_d;
  logic             done_q, done_d;
  logic [BLK_W-1:0] alloc_q, alloc_d;
  status_e          status_q, status_d;
  logic [CFG_W-1:0] tb_q, rb_q;

  // Memory and bit unit hookup
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  bu_op_e               bu_op;
  logic [BIT_W-1:0]     bu_idx;
  logic                 bu_lt, bu_eq;
  bu_res_t              bu_res;

  logic             accept;
  logic             rel_range;
  logic             rsv_sat;
  logic             scan_more;
  logic             found;
  logic [AW-1:0]    blk_word;

  fbba_map #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fbba_bitunit u_bit (
    .op_i      (bu_op),
    .word_i    (mem_rdata),
    .idx_i     (bu_idx),
    .fill_lt_i (bu_lt),
    .fill_eq_i (bu_eq),
    .res_o     (bu_res)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q <= CFG_W'(1024);
      rb_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL:    tb_q <= cfg_data_i;
        CFG_RESERVED: rb_q <= cfg_data_i;
        default:      tb_q <= tb_q;
      endcase
    end
  end

  // Request decode helpers
  assign accept    = start_i && (state_q == S_IDLE);
  assign rel_range = (CFG_W'(block_number_i) >= tb_q) ||
                     (32'(block_number_i[BLK_W-1:BIT_W]) >= 32'(MAP_WORDS));
  assign rsv_sat   = CW'(rb_q[CFG_W-1:BIT_W]) >= CW'(MAP_WORDS);
  assign scan_more = (ptr_q < PW'(MAP_WORDS)) && (CW'(ptr_q) < CW'(tb_q[CFG_W-1:BIT_W]));
  assign found     = pend_q && !bu_res.all_ones;
  assign blk_word  = AW'(blk_q[BLK_W-1:BIT_W]);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    chk_d     = chk_q;
    pend_d    = pend_q;
    clr_d     = clr_q;
    blk_d     = blk_q;
    full_d    = full_q;
    rem_d     = rem_q;
    done_d    = 1'b0;
    alloc_d   = alloc_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q[AW-1:0];
    mem_wdata = bu_res.word;
    mem_raddr = ptr_q[AW-1:0];
    bu_op     = BU_FILL;
    bu_idx    = rem_q;
    bu_lt     = !clr_q && (ptr_q < full_q);
    bu_eq     = !clr_q && (ptr_q == full_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_e'(opcode_i))
            OP_ALLOC: begin
              ptr_d   = '0;
              pend_d  = 1'b0;
              state_d = S_SCAN;
            end
            OP_RELEASE: begin
              if (rel_range) begin
                done_d   = 1'b1;
                alloc_d  = '0;
                status_d = ST_RANGE;
              end else begin
                blk_d   = block_number_i;
                state_d = S_RRD;
              end
            end
            OP_FORMAT: begin
              full_d  = rsv_sat ? PW'(MAP_WORDS) : PW'(rb_q[CFG_W-1:BIT_W]);
              rem_d   = rsv_sat ? '0 : rb_q[BIT_W-1:0];
              ptr_d   = '0;
              clr_d   = 1'b0;
              state_d = S_FMT;
            end
            OP_UNDEF: begin
              done_d   = 1'b1;
              alloc_d  = '0;
              status_d = ST_RANGE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Read word ptr while checking the word read last cycle
      S_SCAN: begin
        bu_op = BU_SET_LOW;
        if (found) begin
          mem_we    = 1'b1;
          mem_waddr = chk_q;
          done_d    = 1'b1;
          alloc_d   = BLK_W'({chk_q, bu_res.low_idx});
          status_d  = ST_OK;
          state_d   = S_IDLE;
        end else if (scan_more) begin
          chk_d  = ptr_q[AW-1:0];
          pend_d = 1'b1;
          ptr_d  = ptr_q + PW'(1);
        end else begin
          done_d   = 1'b1;
          alloc_d  = '0;
          status_d = ST_NOSPACE;
          state_d  = S_IDLE;
        end
      end

      S_RRD: begin
        mem_raddr = blk_word;
        state_d   = S_RCHK;
      end

      // Check the block's bit and clear it if used
      S_RCHK: begin
        bu_op     = BU_CLEAR;
        bu_idx    = blk_q[BIT_W-1:0];
        mem_waddr = blk_word;
        mem_we    = bu_res.hit;
        done_d    = 1'b1;
        alloc_d   = '0;
        status_d  = bu_res.hit ? ST_OK : ST_FREEREL;
        state_d   = S_IDLE;
      end

      // Format or post-reset clear: one word per cycle
      S_FMT: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + PW'(1);
        if (ptr_q == PW'(MAP_WORDS - 1)) begin
          done_d   = !clr_q;
          alloc_d  = '0;
          status_d = ST_OK;
          clr_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FMT;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      clr_q   <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chk_q    <= chk_d;
    blk_q    <= blk_d;
    full_q   <= full_d;
    rem_q    <= rem_d;
    alloc_q  <= alloc_d;
    status_q <= status_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign allocated_block_o = alloc_q;
  assign status_o          = status_q;

`ifndef SYNTHESIS
  // A result is only shown once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A failed allocation grants no block
  a_nospace_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NOSPACE)) |-> (allocated_block_o == '0))
    else $error("no-space result carries a block number");

  // The sequencer only leaves idle on an accepted request
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without a request");
`endif

endmodule
